[sv/tga_rle_pixel_unpacker_macros.svh]
// assertion macros for the tga rle pixel unpacker
// used by the top level of the block; no other dependencies
`ifndef TGA_RLE_PIXEL_UNPACKER_MACROS_SVH
`define TGA_RLE_PIXEL_UNPACKER_MACROS_SVH
`ifndef SYNTHESIS
// check on i_clk, ignored while i_rst_n is low
`define TRPU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// check on i_clk, also during reset
`define TRPU_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);
`else
`define TRPU_ASSERT(label, prop, msg)
`define TRPU_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

[sv/trpu_pkg.sv]
// shared types, constants and helper functions of the tga rle pixel unpacker
// no dependencies
package trpu_pkg;

    localparam int unsigned MAX_DIMENSION = 4096;
    localparam int unsigned MAX_PACKET    = 128;
    localparam int unsigned ADDR_W        = 5;

    localparam logic [12:0] DIM_MAX   = 13'(MAX_DIMENSION);
    localparam logic [12:0] WIDTH_MIN = 13'd4;
    localparam logic [12:0] HEIGHT_MIN = 13'd1;

    // packet header fields
    localparam logic [7:0] HDR_COUNT_MASK = 8'h7F;
    localparam logic [7:0] HDR_REPEAT_BIT = 8'h80;
    localparam logic [7:0] PIXEL_SHIFT    = 8'h20;

    // register indexes
    localparam logic [2:0] REG_BPP    = 3'd0;
    localparam logic [2:0] REG_RLC    = 3'd1;
    localparam logic [2:0] REG_WIDTH  = 3'd2;
    localparam logic [2:0] REG_HEIGHT = 3'd3;
    localparam logic [2:0] REG_TOP    = 3'd4;

    // reset values
    localparam logic [2:0]  RST_BPP    = 3'd3;
    localparam logic        RST_RLC    = 1'b1;
    localparam logic [12:0] RST_WIDTH  = 13'd256;
    localparam logic [12:0] RST_HEIGHT = 13'd256;
    localparam logic        RST_TOP    = 1'b0;

    // effective configuration, already clamped
    typedef struct packed {
        logic [2:0]  bpp;
        logic        rlc;
        logic [12:0] width;
        logic [12:0] height;
        logic        top;
    } t_cfg;

    // result of one pass of the span unit
    typedef struct packed {
        logic        wrap_only;
        logic [7:0]  len;
        logic [11:0] next_col;
        logic [11:0] row_out;
        logic        advance;
        logic [12:0] rows_inc;
        logic        fin;
        logic        last;
    } t_span;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } t_state;

    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_REPEAT = 3'b010,
        PH_RAW    = 3'b100
    } t_phase;

    function automatic logic [12:0] clamp_dim(input logic [12:0] v, input logic [12:0] lo);
        logic [12:0] r;
        r = v;
        if (r < lo) r = lo;
        if (r > DIM_MAX) r = DIM_MAX;
        return r;
    endfunction

    function automatic logic [2:0] clamp_bpp(input logic [2:0] v);
        logic [2:0] r;
        r = v;
        if (r == 3'd0) r = 3'd1;
        if (r > 3'd4) r = 3'd4;
        return r;
    endfunction

    // destination row with optional bottom-up flip
    function automatic logic [11:0] dest_row(input logic [12:0] rows, input logic [12:0] h,
                                             input logic top);
        logic [12:0] r;
        logic [12:0] d;
        r = (rows >= h) ? (h - 13'd1) : rows;
        d = top ? r : (h - 13'd1 - r);
        return d[11:0];
    endfunction

endpackage

[sv/trpu_cfg_regs.sv]
// configuration registers of the tga rle pixel unpacker, apb-style access
// depends on trpu_pkg
module trpu_cfg_regs
    import trpu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic [2:0]  r_bpp;
    logic        r_rlc;
    logic [12:0] r_width;
    logic [12:0] r_height;
    logic        r_top;
    logic        wr_en;
    logic [2:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp    <= RST_BPP;
            r_rlc    <= RST_RLC;
            r_width  <= RST_WIDTH;
            r_height <= RST_HEIGHT;
            r_top    <= RST_TOP;
        end else if (wr_en) begin
            case (reg_idx)
                REG_BPP:    r_bpp    <= pwdata[2:0];
                REG_RLC:    r_rlc    <= pwdata[0];
                REG_WIDTH:  r_width  <= pwdata[12:0];
                REG_HEIGHT: r_height <= pwdata[12:0];
                REG_TOP:    r_top    <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_BPP:    prdata = {29'd0, r_bpp};
            REG_RLC:    prdata = {31'd0, r_rlc};
            REG_WIDTH:  prdata = {19'd0, r_width};
            REG_HEIGHT: prdata = {19'd0, r_height};
            REG_TOP:    prdata = {31'd0, r_top};
            default:    prdata = 32'd0;
        endcase
    end

    always_comb begin
        o_cfg.bpp    = clamp_bpp(r_bpp);
        o_cfg.rlc    = r_rlc;
        o_cfg.width  = clamp_dim(r_width, WIDTH_MIN);
        o_cfg.height = clamp_dim(r_height, HEIGHT_MIN);
        o_cfg.top    = r_top;
    end

endmodule

[sv/trpu_span_unit.sv]
// shared span unit: clips a pending run against the row end, one span per use
// depends on trpu_pkg
module trpu_span_unit
    import trpu_pkg::*;
(
    input  t_cfg        i_cfg,
    input  logic [11:0] i_col,
    input  logic [7:0]  i_count,
    input  logic [12:0] i_rows,
    output t_span       o_span
);

    logic [12:0] col_ext;
    logic [12:0] room;
    logic [12:0] cnt_ext;
    logic [12:0] sum;
    logic        pre;
    logic        fits;

    always_comb begin
        col_ext = {1'b0, i_col};
        cnt_ext = {5'd0, i_count};
        pre     = col_ext >= i_cfg.width;
        room    = i_cfg.width - col_ext;
        fits    = cnt_ext <= room;

        o_span.wrap_only = pre;
        o_span.len       = fits ? i_count : room[7:0];
        sum              = col_ext + {5'd0, o_span.len};
        o_span.advance   = pre || (sum >= i_cfg.width);
        o_span.rows_inc  = i_rows + 13'd1;
        o_span.fin       = o_span.advance && (o_span.rows_inc >= i_cfg.height);
        o_span.next_col  = o_span.advance ? 12'd0 : sum[11:0];
        o_span.row_out   = dest_row(i_rows, i_cfg.height, i_cfg.top);
        o_span.last      = pre ? o_span.fin : (fits || o_span.fin);
    end

endmodule

[sv/tga_rle_pixel_unpacker.sv]
// top level of the tga rle pixel unpacker: byte sequencer, output register
// depends on trpu_pkg, trpu_cfg_regs, trpu_span_unit and the macros header
//
//  channel | direction | handshake                    | payload
//  --------+-----------+------------------------------+---------------------------------
//  in      | to block  | i_in_valid / o_in_stall      | i_data_byte, i_stream_end
//  out     | from block| o_out_valid / i_out_stall    | o_pixel_value .. o_last_of_run
//  cfg     | to block  | psel, penable, pwrite, pready| paddr, pwdata, prdata
//
// a byte is taken while the block is idle and the output register is free
// a completed pixel then emits one span per cycle through the shared span unit while the output
// register is free, wrapping the column first if needed; up to 33 spans for a repeat of 128
// the output register holds a span while the consumer stalls; the sequencer waits on it
// synchronous active-low reset clears all control state; no memory, no clearing pass
`include "tga_rle_pixel_unpacker_macros.svh"
module tga_rle_pixel_unpacker
    import trpu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input byte channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [7:0]        i_data_byte,
    input  logic              i_stream_end,
    // span result channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [31:0]       o_pixel_value,
    output logic [11:0]       o_row_index,
    output logic [11:0]       o_start_column,
    output logic [7:0]        o_span_length,
    output logic              o_image_done,
    output logic              o_data_error,
    output logic              o_last_of_run,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    t_cfg  cfg;
    t_span su;

    // sequencer and packet state
    t_state      r_state,     n_state;
    t_phase      r_phase,     n_phase;
    logic [7:0]  r_remaining, n_remaining;
    logic        r_repeat,    n_repeat;
    logic [1:0]  r_bip,       n_bip;
    logic [31:0] r_asm,       n_asm;
    logic [11:0] r_col,       n_col;
    logic [12:0] r_rows,      n_rows;
    logic        r_finished,  n_finished;
    logic [7:0]  r_count,     n_count;
    logic [31:0] r_value,     n_value;

    // output register
    logic        r_out_valid, n_out_valid;
    logic [31:0] r_pix,       n_pix;
    logic [11:0] r_row,       n_row;
    logic [11:0] r_scol,      n_scol;
    logic [7:0]  r_len,       n_len;
    logic        r_done,      n_done;
    logic        r_err,       n_err;
    logic        r_last,      n_last;

    logic        out_free;
    logic        in_xfer;
    logic        load_out;
    logic        fin_now;
    logic        is_header;
    logic [31:0] asm_new;
    logic [1:0]  bip_inc;
    logic        pix_done;
    logic [7:0]  cnt_sel;

    trpu_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // one span unit serves both the status row and every span of a run
    trpu_span_unit u_span (
        .i_cfg   (cfg),
        .i_col   (r_col),
        .i_count (r_count),
        .i_rows  (r_rows),
        .o_span  (su)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == ST_IDLE) && out_free);
    assign in_xfer    = i_in_valid && !o_in_stall;

    // byte assembly, first byte lands in bits 7:0
    assign asm_new  = r_asm | ({24'd0, i_data_byte} << {r_bip, 3'b000});
    assign bip_inc  = r_bip + 2'd1;
    assign pix_done = (bip_inc == 2'd0) || ({1'b0, bip_inc} >= cfg.bpp);
    assign fin_now  = r_finished || (r_rows >= cfg.height);
    assign is_header = (r_phase != PH_REPEAT) && (r_phase != PH_RAW);

    // a repeat packet hands its whole count to the span unit, otherwise one pixel
    assign cnt_sel = (cfg.rlc && (r_phase == PH_REPEAT)) ? r_remaining : 8'd1;

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_remaining = r_remaining;
        n_repeat    = r_repeat;
        n_bip       = r_bip;
        n_asm       = r_asm;
        n_col       = r_col;
        n_rows      = r_rows;
        n_finished  = r_finished;
        n_count     = r_count;
        n_value     = r_value;
        n_out_valid = r_out_valid && i_out_stall;
        n_pix       = r_pix;
        n_row       = r_row;
        n_scol      = r_scol;
        n_len       = r_len;
        n_done      = r_done;
        n_err       = r_err;
        n_last      = r_last;
        load_out    = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (fin_now) begin
                        // image complete: bytes and stream end are dropped
                        n_finished = 1'b1;
                    end else if (i_stream_end) begin
                        // early end: one status transfer at the current position
                        load_out   = 1'b1;
                        n_pix      = 32'd0;
                        n_row      = su.row_out;
                        n_scol     = r_col;
                        n_len      = 8'd0;
                        n_done     = 1'b0;
                        n_err      = 1'b1;
                        n_last     = 1'b1;
                        n_finished = 1'b1;
                    end else if (cfg.rlc && is_header) begin
                        n_remaining = (i_data_byte & HDR_COUNT_MASK) + 8'd1;
                        n_repeat    = (i_data_byte & HDR_REPEAT_BIT) != 8'd0;
                        n_phase     = n_repeat ? PH_REPEAT : PH_RAW;
                        n_bip       = 2'd0;
                        n_asm       = 32'd0;
                    end else if (!pix_done) begin
                        n_asm = asm_new;
                        n_bip = bip_inc;
                    end else begin
                        n_asm   = 32'd0;
                        n_bip   = 2'd0;
                        n_value = asm_new;
                        n_count = cnt_sel;
                        n_state = ST_EMIT;
                        if (cfg.rlc) begin
                            if (r_phase == PH_REPEAT) begin
                                n_remaining = 8'd0;
                                n_phase     = PH_HEADER;
                            end else if (r_remaining <= 8'd1) begin
                                n_remaining = 8'd0;
                                n_phase     = PH_HEADER;
                            end else begin
                                n_remaining = r_remaining - 8'd1;
                            end
                        end
                    end
                end
            end
            ST_EMIT: begin
                if (su.wrap_only) begin
                    // column past a reduced width: wrap before emitting
                    n_col  = 12'd0;
                    n_rows = su.rows_inc;
                    if (su.fin) begin
                        n_finished = 1'b1;
                        n_state    = ST_IDLE;
                    end
                end else if (out_free) begin
                    load_out   = 1'b1;
                    n_pix      = r_value;
                    n_row      = su.row_out;
                    n_scol     = r_col;
                    n_len      = su.len;
                    n_done     = su.fin;
                    n_err      = 1'b0;
                    n_last     = su.last;
                    n_col      = su.next_col;
                    n_rows     = su.advance ? su.rows_inc : r_rows;
                    n_finished = su.fin;
                    n_count    = r_count - su.len;
                    if (su.last) n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (load_out) n_out_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_HEADER;
            r_remaining <= 8'd0;
            r_repeat    <= 1'b0;
            r_bip       <= 2'd0;
            r_asm       <= 32'd0;
            r_col       <= 12'd0;
            r_rows      <= 13'd0;
            r_finished  <= 1'b0;
            r_count     <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_remaining <= n_remaining;
            r_repeat    <= n_repeat;
            r_bip       <= n_bip;
            r_asm       <= n_asm;
            r_col       <= n_col;
            r_rows      <= n_rows;
            r_finished  <= n_finished;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_pix   <= n_pix;
        r_row   <= n_row;
        r_scol  <= n_scol;
        r_len   <= n_len;
        r_done  <= n_done;
        r_err   <= n_err;
        r_last  <= n_last;
    end

    assign o_out_valid    = r_out_valid;
    assign o_pixel_value  = r_pix;
    assign o_row_index    = r_row;
    assign o_start_column = r_scol;
    assign o_span_length  = r_len;
    assign o_image_done   = r_done;
    assign o_data_error   = r_err;
    assign o_last_of_run  = r_last;

    `TRPU_ASSERT(a_len_vs_err, o_out_valid |-> ((o_span_length != 8'd0) != o_data_error), "len/err")
    `TRPU_ASSERT(a_err_is_last, (o_out_valid && o_data_error) |-> o_last_of_run, "status not last")
    `TRPU_ASSERT(a_no_load_after_fin, r_finished |-> !load_out, "span after finish")
    `TRPU_ASSERT(a_emit_count, (r_state == ST_EMIT) |-> (r_count != 8'd0), "empty run count")
    `TRPU_ASSERT(a_emit_blocks_input, (r_state == ST_EMIT) |=> !$past(in_xfer), "byte in emit")

endmodule
